// ===== hdl/admx_pkg.sv =====
// ----------------------------------------------------------------------------
// admx_pkg
// Shared types and constants of the Art-Net DMX frame filter.
// ----------------------------------------------------------------------------
package admx_pkg;

  localparam int MAX_CHANNELS    = 512;
  localparam int MAX_FRAME_BYTES = 2048;

  localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CW_W   = $clog2(MAX_CHANNELS + 1);
  localparam int IDX_W  = 9;
  localparam int ADDR_W = 3;

  localparam int POS_ETYPE_HI = 12;
  localparam int POS_ETYPE_LO = 13;
  localparam int POS_IP_PROTO = 23;
  localparam int POS_ID_FIRST = 42;
  localparam int POS_ID_LAST  = 49;
  localparam int POS_OPC_LO   = 50;
  localparam int POS_OPC_HI   = 51;
  localparam int POS_SUBUNI   = 56;
  localparam int POS_NET      = 57;
  localparam int POS_LEN_HI   = 58;
  localparam int POS_LEN_LO   = 59;
  localparam int POS_DATA     = 60;

  localparam logic [7:0]  ETYPE_HI = 8'h08;
  localparam logic [7:0]  ETYPE_LO = 8'h00;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] OPC_POLL = 16'h2000;
  localparam logic [15:0] OPC_DMX  = 16'h5000;

  typedef enum logic [ADDR_W-1:0] {
    REG_NET    = 3'd0,
    REG_SUBUNI = 3'd4
  } reg_addr_t;

  typedef enum logic [2:0] {
    KIND_IGNORED    = 3'd0,
    KIND_DMX_STORED = 3'd1,
    KIND_DMX_OTHER  = 3'd2,
    KIND_POLL       = 3'd3,
    KIND_OTHER      = 3'd4
  } kind_t;

  typedef struct packed {
    logic [6:0] net;
    logic [7:0] subuni;
  } cfg_t;

  typedef struct packed {
    logic             write_valid;
    logic [IDX_W-1:0] channel_index;
    logic [7:0]       channel_value;
    logic             frame_done;
    kind_t            frame_kind;
  } res_t;

  function automatic logic [7:0] id_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'h41;
      3'd1: r = 8'h72;
      3'd2: r = 8'h74;
      3'd3: r = 8'h2D;
      3'd4: r = 8'h4E;
      3'd5: r = 8'h65;
      3'd6: r = 8'h74;
      3'd7: r = 8'h00;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/admx_in_if.sv =====
// ----------------------------------------------------------------------------
// admx_in_if
// Byte stream channel carrying frame bytes into the filter.
// ----------------------------------------------------------------------------
interface admx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== hdl/admx_out_if.sv =====
// ----------------------------------------------------------------------------
// admx_out_if
// Result channel carrying channel writes and frame reports.
// ----------------------------------------------------------------------------
interface admx_out_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [8:0] channel_index;
  logic [7:0] channel_value;
  logic       frame_done;
  logic [2:0] frame_kind;

  modport source (output valid, output write_valid, output channel_index,
                  output channel_value, output frame_done, output frame_kind,
                  input ready);
  modport sink   (input valid, input write_valid, input channel_index,
                  input channel_value, input frame_done, input frame_kind,
                  output ready);
endinterface

// ===== hdl/artnet_dmx_frame_filter.sv =====
// ----------------------------------------------------------------------------
// artnet_dmx_frame_filter
// Filters received Ethernet frames for Art-Net ArtDmx packets of one universe
// and turns their data bytes into DMX channel writes.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake        Carries
//   in_chan   sink       valid/ready      frame_byte, frame_end
//   out_chan  source     valid/ready      one result per input byte
//   cfg_*     APB slave  psel/penable     universe net and sub-universe
//
// One byte is accepted per cycle while results drain; each result passes
// through the input register and then the result register.
// Reset is synchronous and active low; it clears the frame state and both
// match registers. A stalled sink holds the result register, and the input
// register keeps taking bytes as long as the result register can drain.
// ----------------------------------------------------------------------------
module artnet_dmx_frame_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  admx_in_if.sink                     in_chan,
  admx_out_if.source                  out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [admx_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import admx_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic res_valid;
  logic res_ready;

  admx_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  admx_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_byte   (in_chan.frame_byte),
    .in_end    (in_chan.frame_end),
    .cfg       (cfg),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  admx_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.write_valid   = out_res.write_valid;
  assign out_chan.channel_index = out_res.channel_index;
  assign out_chan.channel_value = out_res.channel_value;
  assign out_chan.frame_done    = out_res.frame_done;
  assign out_chan.frame_kind    = out_res.frame_kind;

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.write_valid) |->
      (out_chan.channel_index == '0 && out_chan.channel_value == '0))
    else $error("Result without a write carries nonzero channel fields.");

  a_kind_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.frame_done) |-> (out_chan.frame_kind == KIND_IGNORED))
    else $error("Frame kind reported before the last byte.");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid)
    else $error("Input stalled while no result is pending.");

  a_first_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready && res.frame_done) |=>
      ((res_valid && res.write_valid) |-> (res.channel_index == '0)))
    else $error("First write of a frame does not start at channel zero.");
endmodule

// ===== hdl/admx_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// admx_cfg_regs
// APB register file holding the universe net and sub-universe match values.
// ----------------------------------------------------------------------------
module admx_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [admx_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output admx_pkg::cfg_t               cfg
);
  import admx_pkg::*;

  logic [6:0] net_r;
  logic [7:0] subuni_r;
  logic       wr_en;
  logic       sel_subuni;

  assign pready     = 1'b1;
  assign wr_en      = psel && penable && pwrite;
  assign sel_subuni = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_r    <= '0;
      subuni_r <= '0;
    end else if (wr_en) begin
      if (sel_subuni) begin
        subuni_r <= pwdata[7:0];
      end else begin
        net_r <= pwdata[6:0];
      end
    end
  end

  always_comb begin
    unique case (reg_addr_t'({paddr[2], 2'b00}))
      REG_NET:    prdata = {25'd0, net_r};
      REG_SUBUNI: prdata = {24'd0, subuni_r};
      default:    prdata = '0;
    endcase
  end

  assign cfg.net    = net_r;
  assign cfg.subuni = subuni_r;
endmodule

// ===== hdl/admx_parser.sv =====
// ----------------------------------------------------------------------------
// admx_parser
// Input register, per-frame header state; one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module admx_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  input  admx_pkg::cfg_t  cfg,
  input  logic            res_ready,
  output logic            res_valid,
  output admx_pkg::res_t  res
);
  import admx_pkg::*;

  logic             v_r;
  logic [7:0]       b_r;
  logic             end_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hm_r, hm_nxt;
  logic [15:0]      opc_r, opc_nxt;
  logic             um_r, um_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [CW_W-1:0]  cw_r, cw_nxt;
  logic             fire;
  logic             mism;
  logic             wv;
  kind_t            kind;

  assign fire      = v_r && res_ready;
  assign in_ready  = !v_r || res_ready;
  assign res_valid = v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      b_r   <= in_byte;
      end_r <= in_end;
    end
  end

  always_comb begin
    mism = ((pos_r == POS_W'(POS_ETYPE_HI)) && (b_r != ETYPE_HI)) ||
           ((pos_r == POS_W'(POS_ETYPE_LO)) && (b_r != ETYPE_LO)) ||
           ((pos_r == POS_W'(POS_IP_PROTO)) && (b_r != PROTO_UDP)) ||
           ((pos_r >= POS_W'(POS_ID_FIRST)) && (pos_r <= POS_W'(POS_ID_LAST)) &&
            (b_r != id_byte(pos_r[2:0] - 3'd2)));
    hm_nxt  = hm_r && !mism;
    opc_nxt = opc_r;
    if (pos_r == POS_W'(POS_OPC_LO)) opc_nxt = {opc_r[15:8], b_r};
    if (pos_r == POS_W'(POS_OPC_HI)) opc_nxt = {b_r, opc_r[7:0]};
    um_nxt = um_r;
    if (pos_r == POS_W'(POS_SUBUNI)) um_nxt = (b_r == cfg.subuni);
    if (pos_r == POS_W'(POS_NET))    um_nxt = um_r && (b_r == {1'b0, cfg.net});
    len_nxt = len_r;
    if (pos_r == POS_W'(POS_LEN_HI)) len_nxt = {b_r, len_r[7:0]};
    if (pos_r == POS_W'(POS_LEN_LO)) len_nxt = {len_r[15:8], b_r};

    wv = (pos_r >= POS_W'(POS_DATA)) && (pos_r < POS_W'(MAX_FRAME_BYTES)) &&
         hm_nxt && (opc_nxt == OPC_DMX) && um_nxt &&
         (16'(cw_r) < len_nxt) && (cw_r < CW_W'(MAX_CHANNELS));

    priority if (!hm_nxt || (pos_r < POS_W'(POS_OPC_HI))) begin
      kind = KIND_IGNORED;
    end else if (opc_nxt == OPC_POLL) begin
      kind = KIND_POLL;
    end else if (opc_nxt == OPC_DMX) begin
      kind = ((pos_r >= POS_W'(POS_NET)) && um_nxt) ? KIND_DMX_STORED : KIND_DMX_OTHER;
    end else begin
      kind = KIND_OTHER;
    end

    res.write_valid   = wv;
    res.channel_index = wv ? IDX_W'(cw_r) : '0;
    res.channel_value = wv ? b_r : 8'd0;
    res.frame_done    = end_r;
    res.frame_kind    = end_r ? kind : KIND_IGNORED;

    if (end_r) begin
      pos_nxt = '0;
      hm_nxt  = 1'b1;
      opc_nxt = '0;
      um_nxt  = 1'b0;
      len_nxt = '0;
      cw_nxt  = '0;
    end else begin
      pos_nxt = (pos_r < POS_W'(MAX_FRAME_BYTES)) ? pos_r + POS_W'(1) : pos_r;
      cw_nxt  = cw_r + CW_W'(wv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hm_r  <= 1'b1;
      opc_r <= '0;
      um_r  <= 1'b0;
      len_r <= '0;
      cw_r  <= '0;
    end else if (fire) begin
      pos_r <= pos_nxt;
      hm_r  <= hm_nxt;
      opc_r <= opc_nxt;
      um_r  <= um_nxt;
      len_r <= len_nxt;
      cw_r  <= cw_nxt;
    end
  end
endmodule

// ===== hdl/admx_out_stage.sv =====
// ----------------------------------------------------------------------------
// admx_out_stage
// Result register that holds a finished result until the sink takes it.
// ----------------------------------------------------------------------------
module admx_out_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_valid,
  output logic            res_ready,
  input  admx_pkg::res_t  res,
  output logic            out_valid,
  input  logic            out_ready,
  output admx_pkg::res_t  out_res
);
  import admx_pkg::*;

  logic valid_r;
  res_t res_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end
endmodule

// ===== tb/artnet_dmx_frame_filter_test.sv =====
// ----------------------------------------------------------------------------
// artnet_dmx_frame_filter_test
// Drives whole Ethernet frames into the Art-Net DMX frame filter, byte by byte,
// and checks every result against a cycle-free model of the filter kept here.
// A directed set of frames covers short frames, all kinds but KIND_OTHER, a
// header error, Length limits and a universe change in mid-frame.
// Random frames follow under several universe settings and idling patterns.
// ----------------------------------------------------------------------------
module artnet_dmx_frame_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import admx_pkg::*;

  localparam int          PIPE_LAT    = 2;
  localparam int          PHASE_BYTES = 100;
  localparam logic [63:0] ID_TEXT     = 64'h4172742D_4E657400;

  typedef struct {
    logic [15:0] opcode;
    logic [7:0]  subuni;
    logic [7:0]  net;
    logic [15:0] dmx_len;
    int          data_bytes;
    int          cut_at;
    int          bad_pos;
    int          retune_at;
    bit          noise;
    bit          kind_known;
    kind_t       kind;
  } frame_spec_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  admx_in_if  in_chan ();
  admx_out_if out_chan ();

  artnet_dmx_frame_filter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  int   gap_pct     = 0;
  int   stall_pct   = 0;
  int   fail_count  = 0;
  int   bytes_sent  = 0;
  int   frames_sent = 0;
  int   writes_seen = 0;
  int   kinds_seen [8];
  res_t pending_results [$];
  frame_spec_t directed_frames [$];

  logic [6:0]  univ_net    = '0;
  logic [7:0]  univ_subuni = '0;
  int          fpos        = 0;
  bit          hdr_ok      = 1'b1;
  logic [15:0] opcode_seen = '0;
  bit          uni_ok      = 1'b0;
  logic [15:0] dmx_len     = '0;
  int          written     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t next_dmx_result(input logic [7:0] b, input logic last);
    res_t r;
    r = '0;
    r.frame_kind = KIND_IGNORED;
    if (fpos == POS_ETYPE_HI && b != ETYPE_HI) hdr_ok = 1'b0;
    if (fpos == POS_ETYPE_LO && b != ETYPE_LO) hdr_ok = 1'b0;
    if (fpos == POS_IP_PROTO && b != PROTO_UDP) hdr_ok = 1'b0;
    if (fpos >= POS_ID_FIRST && fpos <= POS_ID_LAST &&
        b != ID_TEXT[8*(POS_ID_LAST - fpos) +: 8]) hdr_ok = 1'b0;
    if (fpos == POS_OPC_LO) opcode_seen[7:0] = b;
    if (fpos == POS_OPC_HI) opcode_seen[15:8] = b;
    if (fpos == POS_SUBUNI) uni_ok = (b == univ_subuni);
    if (fpos == POS_NET) uni_ok = uni_ok && (b == {1'b0, univ_net});
    if (fpos == POS_LEN_HI) dmx_len[15:8] = b;
    if (fpos == POS_LEN_LO) dmx_len[7:0] = b;
    if (fpos >= POS_DATA && fpos < MAX_FRAME_BYTES && hdr_ok && opcode_seen == OPC_DMX &&
        uni_ok && written < int'(dmx_len) && written < MAX_CHANNELS) begin
      r.write_valid   = 1'b1;
      r.channel_index = 9'(written);
      r.channel_value = b;
      written++;
    end
    if (last) begin
      r.frame_done = 1'b1;
      if (!hdr_ok || fpos < POS_OPC_HI) begin
        r.frame_kind = KIND_IGNORED;
      end else if (opcode_seen == OPC_POLL) begin
        r.frame_kind = KIND_POLL;
      end else if (opcode_seen == OPC_DMX) begin
        r.frame_kind = (fpos >= POS_NET && uni_ok) ? KIND_DMX_STORED : KIND_DMX_OTHER;
      end else begin
        r.frame_kind = KIND_OTHER;
      end
      fpos        = 0;
      hdr_ok      = 1'b1;
      opcode_seen = '0;
      uni_ok      = 1'b0;
      dmx_len     = '0;
      written     = 0;
    end else if (fpos < MAX_FRAME_BYTES) begin
      fpos++;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic write_reg(input reg_addr_t addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == REG_NET) begin
      univ_net = value[6:0];
    end else begin
      univ_subuni = value[7:0];
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(negedge clk);
  endtask

  task automatic set_universe(input logic [6:0] net, input logic [7:0] subuni);
    write_reg(REG_NET, {25'($urandom()), net});
    write_reg(REG_SUBUNI, {24'($urandom()), subuni});
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input bit kind_known,
                           input kind_t kind);
    res_t r;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.frame_byte <= b;
    in_chan.frame_end  <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    r = next_dmx_result(b, last);
    if (last && kind_known) r.frame_kind = kind;
    pending_results.push_back(r);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_spec_t f);
    int         flen;
    logic [7:0] b;
    flen = (f.cut_at > 0) ? f.cut_at : POS_DATA + f.data_bytes;
    frames_sent++;
    for (int i = 0; i < flen; i++) begin
      b = 8'($urandom_range(0, 255));
      if (!f.noise) begin
        if (i == POS_ETYPE_HI) b = ETYPE_HI;
        if (i == POS_ETYPE_LO) b = ETYPE_LO;
        if (i == POS_IP_PROTO) b = PROTO_UDP;
        if (i >= POS_ID_FIRST && i <= POS_ID_LAST) b = ID_TEXT[8*(POS_ID_LAST - i) +: 8];
        if (i == POS_OPC_LO) b = f.opcode[7:0];
        if (i == POS_OPC_HI) b = f.opcode[15:8];
        if (i == POS_SUBUNI) b = f.subuni;
        if (i == POS_NET) b = f.net;
        if (i == POS_LEN_HI) b = f.dmx_len[15:8];
        if (i == POS_LEN_LO) b = f.dmx_len[7:0];
        if (i == f.bad_pos) b = b ^ 8'($urandom_range(1, 255));
      end
      if (i == f.retune_at) begin
        wait_drained();
        set_universe(f.net[6:0], f.subuni);
      end
      send_byte(b, i == flen - 1, f.kind_known, f.kind);
    end
  endtask

  function automatic frame_spec_t row(input logic [15:0] opc, input logic [7:0] subuni,
                                      input logic [7:0] net, input logic [15:0] len,
                                      input int data, input int cut, input int bad,
                                      input int retune, input bit known, input kind_t kind);
    frame_spec_t f;
    f.opcode     = opc;
    f.subuni     = subuni;
    f.net        = net;
    f.dmx_len    = len;
    f.data_bytes = data;
    f.cut_at     = cut;
    f.bad_pos    = bad;
    f.retune_at  = retune;
    f.noise      = 1'b0;
    f.kind_known = known;
    f.kind       = kind;
    return f;
  endfunction

  function automatic frame_spec_t random_frame();
    frame_spec_t f;
    int          r;
    int          pick;
    f = row(OPC_DMX, univ_subuni, {1'b0, univ_net}, 16'($urandom_range(0, 16)),
            $urandom_range(0, 16), -1, -1, -1, 1'b0, KIND_IGNORED);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      f.opcode = OPC_POLL;
    end else if (r < 20) begin
      f.opcode = 16'($urandom());
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      f.subuni = 8'($urandom());
    end else if (r < 14) begin
      f.net = 8'($urandom());
    end else if (r < 18) begin
      f.net = {1'b1, univ_net};
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      f.dmx_len = 16'($urandom());
    end else if (r < 14) begin
      f.dmx_len = 16'hFFFF;
    end else if (r < 30) begin
      f.dmx_len    = 16'($urandom_range(0, 8));
      f.data_bytes = int'(f.dmx_len) + $urandom_range(0, 16);
    end
    if ($urandom_range(0, 99) < 10) f.cut_at = $urandom_range(1, POS_DATA + f.data_bytes);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      pick = $urandom_range(0, 10);
      f.bad_pos = (pick == 0) ? POS_ETYPE_HI : (pick == 1) ? POS_ETYPE_LO :
                  (pick == 2) ? POS_IP_PROTO : POS_ID_FIRST + pick - 3;
    end else if (r < 12) begin
      f.bad_pos = $urandom_range(0, POS_DATA - 1);
    end
    if ($urandom_range(0, 99) < 5) begin
      f.noise  = 1'b1;
      f.cut_at = $urandom_range(1, 80);
    end
    return f;
  endfunction

  always @(negedge clk) out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected, channel_index",
                        out_chan.channel_index, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_chan.write_valid !== want.write_valid)
          report_mismatch("write_valid", out_chan.write_valid, want.write_valid);
        if (out_chan.channel_index !== want.channel_index)
          report_mismatch("channel_index", out_chan.channel_index, want.channel_index);
        if (out_chan.channel_value !== want.channel_value)
          report_mismatch("channel_value", out_chan.channel_value, want.channel_value);
        if (out_chan.frame_done !== want.frame_done)
          report_mismatch("frame_done", out_chan.frame_done, want.frame_done);
        if (out_chan.frame_kind !== want.frame_kind)
          report_mismatch("frame_kind", out_chan.frame_kind, want.frame_kind);
      end
      if (out_chan.write_valid === 1'b1) writes_seen++;
      if (out_chan.frame_done === 1'b1) kinds_seen[out_chan.frame_kind]++;
    end
  end

  initial begin
    int target;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.frame_byte = '0;
    in_chan.frame_end  = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = REG_NET;
    cfg_pwdata         = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    gap_pct   = 12;
    stall_pct = 69;
    directed_frames.push_back(row(OPC_DMX, 0, 0, 0, 0, 1, -1, -1, 1, KIND_IGNORED));
    directed_frames.push_back(row(OPC_DMX, 0, 0, 8, 0, 51, -1, -1, 1, KIND_IGNORED));
    directed_frames.push_back(row(OPC_DMX, 0, 0, 8, 0, 57, -1, -1, 1, KIND_DMX_OTHER));
    directed_frames.push_back(row(OPC_DMX, 0, 0, 8, 0, 58, -1, -1, 1, KIND_DMX_STORED));
    directed_frames.push_back(row(OPC_POLL, 0, 0, 0, 0, 52, -1, -1, 1, KIND_POLL));
    directed_frames.push_back(row(OPC_DMX, 0, 0, 4, 12, -1, -1, -1, 1, KIND_DMX_STORED));
    directed_frames.push_back(row(OPC_DMX, 0, 0, 40, 6, -1, -1, -1, 1, KIND_DMX_STORED));
    directed_frames.push_back(row(OPC_DMX, 0, 8'h80, 8, 2, -1, -1, -1, 1, KIND_DMX_OTHER));
    directed_frames.push_back(row(OPC_POLL, 0, 0, 0, 0, 52, POS_ETYPE_HI, -1, 1,
                                  KIND_IGNORED));
    directed_frames.push_back(row(OPC_DMX, 8'hFF, 8'h7F, 8, 8, -1, -1, POS_OPC_HI + 2, 1,
                                  KIND_DMX_STORED));
    foreach (directed_frames[k]) send_frame(directed_frames[k]);

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      if (phase == 0) begin
        set_universe(7'h7F, 8'hFF);
      end else if (phase == 1) begin
        gap_pct   = 69;
        stall_pct = 12;
        set_universe(7'($urandom()), 8'($urandom()));
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
        set_universe(7'h00, 8'h00);
      end
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) send_frame(random_frame());
    end

    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * PIPE_LAT) @(posedge clk);
    $display("Run covered %0d frames, %0d bytes and %0d channel writes.",
             frames_sent, bytes_sent, writes_seen);
    $display("Frames seen: ignored %0d, stored %0d, other universe %0d, poll %0d, other %0d.",
             kinds_seen[KIND_IGNORED], kinds_seen[KIND_DMX_STORED], kinds_seen[KIND_DMX_OTHER],
             kinds_seen[KIND_POLL], kinds_seen[KIND_OTHER]);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results still expected.", pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
